FILE: rtl/core/cpualu_pkg.sv
// Shared types and constants of the 8-bit CPU ALU with flags.
package cpualu_pkg;

    localparam int unsigned ModeW = 5;
    localparam int unsigned WordW = 16;
    localparam int unsigned ByteW = 8;
    localparam int unsigned BitIdxW = 3;

    typedef enum logic [ModeW-1:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_AND   = 5'd4,
        OP_OR    = 5'd5,
        OP_XOR   = 5'd6,
        OP_CP    = 5'd7,
        OP_INC   = 5'd8,
        OP_DEC   = 5'd9,
        OP_RLC   = 5'd10,
        OP_RRC   = 5'd11,
        OP_RL    = 5'd12,
        OP_RR    = 5'd13,
        OP_SLA   = 5'd14,
        OP_SRA   = 5'd15,
        OP_SRL   = 5'd16,
        OP_SWAP  = 5'd17,
        OP_BIT   = 5'd18,
        OP_RES   = 5'd19,
        OP_SET   = 5'd20,
        OP_DAA   = 5'd21,
        OP_CPL   = 5'd22,
        OP_CCF   = 5'd23,
        OP_SCF   = 5'd24,
        OP_RLCA  = 5'd25,
        OP_RRCA  = 5'd26,
        OP_RLA   = 5'd27,
        OP_RRA   = 5'd28,
        OP_ADD16 = 5'd29,
        OP_ADDSP = 5'd30
    } alu_op_t;

    localparam logic [ByteW-1:0] DaaLowFix  = 8'h06;
    localparam logic [ByteW-1:0] DaaHighFix = 8'h60;
    localparam logic [ByteW-1:0] DaaHighLim = 8'h99;
    localparam logic [3:0]       DaaLowLim  = 4'h9;

    typedef struct packed {
        logic [ModeW-1:0]   mode;
        logic [WordW-1:0]   operand_a;
        logic [WordW-1:0]   operand_b;
        logic [BitIdxW-1:0] bit_index;
        logic               zero_in;
        logic               subtract_in;
        logic               half_carry_in;
        logic               carry_in;
    } req_t;

    typedef struct packed {
        logic [WordW-1:0] result;
        logic             zero_out;
        logic             subtract_out;
        logic             half_carry_out;
        logic             carry_out;
    } rsp_t;

endpackage

FILE: rtl/core/cpu_alu_with_flags.sv
// Top level: registered 8-bit CPU ALU with Z/N/H/C flags.
// Each request is held in the input register, then in the result register until it transfers.
// Throughput: one operation per cycle unless rsp_stall holds a full result register; the flag
// and result logic is a single pass between the input register and the result register.
// A full result register that is stalled holds back the input register only when both are full.
// Reset (rst_n low, asynchronous) empties both registers; no other state.
module cpu_alu_with_flags (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  cpualu_pkg::req_t  req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output cpualu_pkg::rsp_t  rsp
);

    logic             s1_valid_reg;
    logic             s1_valid_next;
    cpualu_pkg::req_t s1_reg;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    cpualu_pkg::rsp_t rsp_reg;
    cpualu_pkg::rsp_t rsp_next;
    logic             advance;
    logic             req_xfer;

    assign advance        = !rsp_valid_reg || !rsp_stall;
    assign req_stall      = s1_valid_reg && !advance;
    assign req_xfer       = req_valid && !req_stall;
    assign s1_valid_next  = req_xfer || (s1_valid_reg && !advance);
    assign rsp_valid_next = advance ? s1_valid_reg : rsp_valid_reg;
    assign rsp_valid      = rsp_valid_reg;
    assign rsp            = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            s1_reg <= req;
        end
        if (advance && s1_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_comb
    begin
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  v;
        logic [7:0]  r8;
        logic [7:0]  mask;
        logic [7:0]  corr;
        logic [8:0]  sum9;
        logic [4:0]  sum5;
        logic [16:0] sum17;
        logic [12:0] sum13;
        logic [15:0] r16;
        logic        t;
        logic        z;
        logic        n;
        logic        h;
        logic        c;

        a     = s1_reg.operand_a[7:0];
        b     = s1_reg.operand_b[7:0];
        z     = s1_reg.zero_in;
        n     = s1_reg.subtract_in;
        h     = s1_reg.half_carry_in;
        c     = s1_reg.carry_in;
        r16   = s1_reg.operand_a;
        r8    = 8'h00;
        v     = b;
        corr  = 8'h00;
        sum9  = 9'h000;
        sum5  = 5'h00;
        sum17 = 17'h00000;
        sum13 = 13'h0000;
        t     = 1'b0;
        mask  = 8'h01 << s1_reg.bit_index;

        case (cpualu_pkg::alu_op_t'(s1_reg.mode))
            cpualu_pkg::OP_ADD, cpualu_pkg::OP_ADC:
            begin
                t    = (s1_reg.mode == cpualu_pkg::OP_ADC) ? c : 1'b0;
                sum9 = {1'b0, a} + {1'b0, b} + {8'h00, t};
                sum5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, t};
                r8   = sum9[7:0];
                r16  = {8'h00, r8};
                n    = 1'b0;
                h    = sum5[4];
                c    = sum9[8];
                z    = (r8 == 8'h00);
            end
            cpualu_pkg::OP_SUB, cpualu_pkg::OP_SBC, cpualu_pkg::OP_CP:
            begin
                t    = (s1_reg.mode == cpualu_pkg::OP_SBC) ? c : 1'b0;
                sum9 = {1'b0, a} - {1'b0, b} - {8'h00, t};
                sum5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, t};
                r8   = sum9[7:0];
                n    = 1'b1;
                h    = sum5[4];
                c    = sum9[8];
                z    = (r8 == 8'h00);
                r16  = (s1_reg.mode == cpualu_pkg::OP_CP) ? {8'h00, a} : {8'h00, r8};
            end
            cpualu_pkg::OP_AND:
            begin
                r8  = a & b;
                r16 = {8'h00, r8};
                z   = (r8 == 8'h00);
                n   = 1'b0;
                h   = 1'b1;
                c   = 1'b0;
            end
            cpualu_pkg::OP_OR:
            begin
                r8  = a | b;
                r16 = {8'h00, r8};
                z   = (r8 == 8'h00);
                n   = 1'b0;
                h   = 1'b0;
                c   = 1'b0;
            end
            cpualu_pkg::OP_XOR:
            begin
                r8  = a ^ b;
                r16 = {8'h00, r8};
                z   = (r8 == 8'h00);
                n   = 1'b0;
                h   = 1'b0;
                c   = 1'b0;
            end
            cpualu_pkg::OP_INC:
            begin
                r8  = b + 8'h01;
                r16 = {8'h00, r8};
                z   = (r8 == 8'h00);
                n   = 1'b0;
                h   = (r8[3:0] == 4'h0);
            end
            cpualu_pkg::OP_DEC:
            begin
                r8  = b - 8'h01;
                r16 = {8'h00, r8};
                z   = (r8 == 8'h00);
                n   = 1'b1;
                h   = (r8[3:0] == 4'hF);
            end
            cpualu_pkg::OP_RLC, cpualu_pkg::OP_RLCA:
            begin
                v   = (s1_reg.mode == cpualu_pkg::OP_RLCA) ? a : b;
                r8  = {v[6:0], v[7]};
                c   = v[7];
                r16 = {8'h00, r8};
                n   = 1'b0;
                h   = 1'b0;
                z   = (s1_reg.mode == cpualu_pkg::OP_RLCA) ? 1'b0 : (r8 == 8'h00);
            end
            cpualu_pkg::OP_RRC, cpualu_pkg::OP_RRCA:
            begin
                v   = (s1_reg.mode == cpualu_pkg::OP_RRCA) ? a : b;
                r8  = {v[0], v[7:1]};
                c   = v[0];
                r16 = {8'h00, r8};
                n   = 1'b0;
                h   = 1'b0;
                z   = (s1_reg.mode == cpualu_pkg::OP_RRCA) ? 1'b0 : (r8 == 8'h00);
            end
            cpualu_pkg::OP_RL, cpualu_pkg::OP_RLA:
            begin
                v   = (s1_reg.mode == cpualu_pkg::OP_RLA) ? a : b;
                r8  = {v[6:0], c};
                c   = v[7];
                r16 = {8'h00, r8};
                n   = 1'b0;
                h   = 1'b0;
                z   = (s1_reg.mode == cpualu_pkg::OP_RLA) ? 1'b0 : (r8 == 8'h00);
            end
            cpualu_pkg::OP_RR, cpualu_pkg::OP_RRA:
            begin
                v   = (s1_reg.mode == cpualu_pkg::OP_RRA) ? a : b;
                r8  = {c, v[7:1]};
                c   = v[0];
                r16 = {8'h00, r8};
                n   = 1'b0;
                h   = 1'b0;
                z   = (s1_reg.mode == cpualu_pkg::OP_RRA) ? 1'b0 : (r8 == 8'h00);
            end
            cpualu_pkg::OP_SLA:
            begin
                r8  = {b[6:0], 1'b0};
                c   = b[7];
                r16 = {8'h00, r8};
                n   = 1'b0;
                h   = 1'b0;
                z   = (r8 == 8'h00);
            end
            cpualu_pkg::OP_SRA:
            begin
                r8  = {b[7], b[7:1]};
                c   = b[0];
                r16 = {8'h00, r8};
                n   = 1'b0;
                h   = 1'b0;
                z   = (r8 == 8'h00);
            end
            cpualu_pkg::OP_SRL:
            begin
                r8  = {1'b0, b[7:1]};
                c   = b[0];
                r16 = {8'h00, r8};
                n   = 1'b0;
                h   = 1'b0;
                z   = (r8 == 8'h00);
            end
            cpualu_pkg::OP_SWAP:
            begin
                r8  = {b[3:0], b[7:4]};
                c   = 1'b0;
                r16 = {8'h00, r8};
                n   = 1'b0;
                h   = 1'b0;
                z   = (r8 == 8'h00);
            end
            cpualu_pkg::OP_BIT:
            begin
                r16 = {8'h00, b};
                z   = ((b & mask) == 8'h00);
                n   = 1'b0;
                h   = 1'b1;
            end
            cpualu_pkg::OP_RES:
            begin
                r16 = {8'h00, b & ~mask};
            end
            cpualu_pkg::OP_SET:
            begin
                r16 = {8'h00, b | mask};
            end
            cpualu_pkg::OP_DAA:
            begin
                // carry only ever sets here
                corr = c ? cpualu_pkg::DaaHighFix : 8'h00;
                if (h || (!n && (a[3:0] > cpualu_pkg::DaaLowLim)))
                begin
                    corr = corr | cpualu_pkg::DaaLowFix;
                end
                if (c || (!n && (a > cpualu_pkg::DaaHighLim)))
                begin
                    corr = corr | cpualu_pkg::DaaHighFix;
                end
                r8  = n ? (a - corr) : (a + corr);
                r16 = {8'h00, r8};
                c   = c | corr[6];
                h   = 1'b0;
                z   = (r8 == 8'h00);
            end
            cpualu_pkg::OP_CPL:
            begin
                r16 = {8'h00, ~a};
                n   = 1'b1;
                h   = 1'b1;
            end
            cpualu_pkg::OP_CCF:
            begin
                r16 = {8'h00, a};
                n   = 1'b0;
                h   = 1'b0;
                c   = !c;
            end
            cpualu_pkg::OP_SCF:
            begin
                r16 = {8'h00, a};
                n   = 1'b0;
                h   = 1'b0;
                c   = 1'b1;
            end
            cpualu_pkg::OP_ADD16:
            begin
                sum17 = {1'b0, s1_reg.operand_a} + {1'b0, s1_reg.operand_b};
                sum13 = {1'b0, s1_reg.operand_a[11:0]} + {1'b0, s1_reg.operand_b[11:0]};
                r16   = sum17[15:0];
                n     = 1'b0;
                h     = sum13[12];
                c     = sum17[16];
            end
            cpualu_pkg::OP_ADDSP:
            begin
                r16  = s1_reg.operand_a + {{8{b[7]}}, b};
                sum9 = {1'b0, s1_reg.operand_a[7:0]} + {1'b0, b};
                sum5 = {1'b0, s1_reg.operand_a[3:0]} + {1'b0, b[3:0]};
                z    = 1'b0;
                n    = 1'b0;
                h    = sum5[4];
                c    = sum9[8];
            end
            default:
            begin
                r16 = s1_reg.operand_a;
            end
        endcase

        rsp_next.result         = r16;
        rsp_next.zero_out       = z;
        rsp_next.subtract_out   = n;
        rsp_next.half_carry_out = h;
        rsp_next.carry_out      = c;
    end

    a_xfer_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> s1_valid_reg)
        else $error("request transfer did not load the input register");

    a_s1_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance) |=> rsp_valid_reg)
        else $error("input register advanced without a result");

    a_byte_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_reg.mode <= cpualu_pkg::OP_RRA))
            |-> (rsp_next.result[15:8] == 8'h00))
        else $error("byte operation left a non-zero high byte");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |-> (!s1_valid_reg || advance))
        else $error("input register overwritten while held");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the 8-bit CPU ALU with Z/N/H/C flags.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [cpualu_pkg::ModeW-1:0] UnusedCode = 5'd31;
    localparam logic [7:0]       ByteCorners [8] =
        '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h80, 8'h7F, 8'h99, 8'h9A};

    typedef struct {
        cpualu_pkg::req_t src;
        cpualu_pkg::rsp_t want;
    } owed_t;

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    cpualu_pkg::req_t req;
    logic             rsp_valid;
    logic             rsp_stall;
    cpualu_pkg::rsp_t rsp;

    owed_t       owed_results[$];
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned ops_sent;
    bit [31:0]   codes_seen;
    int          send_calm;
    int          recv_calm;

    cpu_alu_with_flags dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic cpualu_pkg::rsp_t alu_predict(cpualu_pkg::req_t q);
        logic [7:0]       a;
        logic [7:0]       b;
        logic [7:0]       v;
        logic [7:0]       r8;
        logic [7:0]       fix;
        logic [8:0]       wide9;
        logic [4:0]       nib;
        logic [12:0]      wide13;
        logic [16:0]      wide17;
        logic             cin;
        logic             z;
        logic             n;
        logic             h;
        logic             c;
        logic             byte_op;
        cpualu_pkg::rsp_t o;
        a = q.operand_a[7:0];
        b = q.operand_b[7:0];
        z = q.zero_in;
        n = q.subtract_in;
        h = q.half_carry_in;
        c = q.carry_in;
        r8 = 8'h00;
        byte_op = 1'b1;
        o.result = q.operand_a;
        case (q.mode)
            cpualu_pkg::OP_ADD, cpualu_pkg::OP_ADC:
            begin
                cin = (q.mode == cpualu_pkg::OP_ADC) & c;
                wide9 = {1'b0, a} + {1'b0, b} + 9'(cin);
                nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + 5'(cin);
                r8 = wide9[7:0];
                n = 1'b0;
                h = nib[4];
                c = wide9[8];
                z = (r8 == 8'h00);
            end
            cpualu_pkg::OP_SUB, cpualu_pkg::OP_SBC, cpualu_pkg::OP_CP:
            begin
                cin = (q.mode == cpualu_pkg::OP_SBC) & c;
                wide9 = {1'b0, a} - {1'b0, b} - 9'(cin);
                nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - 5'(cin);
                r8 = wide9[7:0];
                n = 1'b1;
                h = nib[4];
                c = wide9[8];
                z = (r8 == 8'h00);
                if (q.mode == cpualu_pkg::OP_CP)
                    r8 = a;
            end
            cpualu_pkg::OP_AND:
            begin
                r8 = a & b;
                z = (r8 == 8'h00);
                {n, h, c} = 3'b010;
            end
            cpualu_pkg::OP_OR:
            begin
                r8 = a | b;
                z = (r8 == 8'h00);
                {n, h, c} = 3'b000;
            end
            cpualu_pkg::OP_XOR:
            begin
                r8 = a ^ b;
                z = (r8 == 8'h00);
                {n, h, c} = 3'b000;
            end
            cpualu_pkg::OP_INC:
            begin
                r8 = b + 8'd1;
                z = (r8 == 8'h00);
                n = 1'b0;
                h = (r8[3:0] == 4'h0);
            end
            cpualu_pkg::OP_DEC:
            begin
                r8 = b - 8'd1;
                z = (r8 == 8'h00);
                n = 1'b1;
                h = (r8[3:0] == 4'hF);
            end
            cpualu_pkg::OP_RLC, cpualu_pkg::OP_RRC, cpualu_pkg::OP_RL,
            cpualu_pkg::OP_RR, cpualu_pkg::OP_SLA, cpualu_pkg::OP_SRA,
            cpualu_pkg::OP_SRL, cpualu_pkg::OP_SWAP,
            cpualu_pkg::OP_RLCA, cpualu_pkg::OP_RRCA, cpualu_pkg::OP_RLA,
            cpualu_pkg::OP_RRA:
            begin
                v = (q.mode >= cpualu_pkg::OP_RLCA) ? a : b;
                case (q.mode)
                    cpualu_pkg::OP_RLC, cpualu_pkg::OP_RLCA:
                        {c, r8} = {v[7], v[6:0], v[7]};
                    cpualu_pkg::OP_RRC, cpualu_pkg::OP_RRCA:
                        {c, r8} = {v[0], v[0], v[7:1]};
                    cpualu_pkg::OP_RL, cpualu_pkg::OP_RLA:
                        {c, r8} = {v[7], v[6:0], c};
                    cpualu_pkg::OP_RR, cpualu_pkg::OP_RRA:
                        {c, r8} = {v[0], c, v[7:1]};
                    cpualu_pkg::OP_SLA:
                        {c, r8} = {v[7], v[6:0], 1'b0};
                    cpualu_pkg::OP_SRA:
                        {c, r8} = {v[0], v[7], v[7:1]};
                    cpualu_pkg::OP_SRL:
                        {c, r8} = {v[0], 1'b0, v[7:1]};
                    default:
                        {c, r8} = {1'b0, v[3:0], v[7:4]};
                endcase
                n = 1'b0;
                h = 1'b0;
                // accumulator forms always clear Z
                z = (q.mode >= cpualu_pkg::OP_RLCA) ? 1'b0 : (r8 == 8'h00);
            end
            cpualu_pkg::OP_BIT:
            begin
                r8 = b;
                z = ~b[q.bit_index];
                n = 1'b0;
                h = 1'b1;
            end
            cpualu_pkg::OP_RES: r8 = b & ~(8'd1 << q.bit_index);
            cpualu_pkg::OP_SET: r8 = b | (8'd1 << q.bit_index);
            cpualu_pkg::OP_DAA:
            begin
                // C is only ever set here, never cleared
                fix = c ? cpualu_pkg::DaaHighFix : 8'h00;
                if (h || (!n && a[3:0] > cpualu_pkg::DaaLowLim))
                    fix = fix | cpualu_pkg::DaaLowFix;
                if (c || (!n && a > cpualu_pkg::DaaHighLim))
                    fix = fix | cpualu_pkg::DaaHighFix;
                r8 = n ? (a - fix) : (a + fix);
                if (fix[6])
                    c = 1'b1;
                h = 1'b0;
                z = (r8 == 8'h00);
            end
            cpualu_pkg::OP_CPL:
            begin
                r8 = ~a;
                n = 1'b1;
                h = 1'b1;
            end
            cpualu_pkg::OP_CCF:
            begin
                r8 = a;
                {n, h, c} = {2'b00, ~c};
            end
            cpualu_pkg::OP_SCF:
            begin
                r8 = a;
                {n, h, c} = 3'b001;
            end
            cpualu_pkg::OP_ADD16:
            begin
                byte_op = 1'b0;
                wide17 = {1'b0, q.operand_a} + {1'b0, q.operand_b};
                wide13 = {1'b0, q.operand_a[11:0]} + {1'b0, q.operand_b[11:0]};
                o.result = wide17[15:0];
                n = 1'b0;
                h = wide13[12];
                c = wide17[16];
            end
            cpualu_pkg::OP_ADDSP:
            begin
                byte_op = 1'b0;
                o.result = q.operand_a + {{8{b[7]}}, b};
                nib = {1'b0, q.operand_a[3:0]} + {1'b0, b[3:0]};
                wide9 = {1'b0, q.operand_a[7:0]} + {1'b0, b};
                z = 1'b0;
                n = 1'b0;
                h = nib[4];
                c = wide9[8];
            end
            default: byte_op = 1'b0;
        endcase
        if (byte_op)
            o.result = {8'h00, r8};
        o.zero_out = z;
        o.subtract_out = n;
        o.half_carry_out = h;
        o.carry_out = c;
        return o;
    endfunction

    // wait before the next transfer, with occasional stretches of back-to-back traffic
    function automatic int draw_wait(ref int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return {8'($urandom), ByteCorners[$urandom_range(0, 7)]};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic send_op(input logic [cpualu_pkg::ModeW-1:0] op, input logic [15:0] a,
                           input logic [15:0] b, input logic [2:0] idx,
                           input logic [3:0] znhc);
        cpualu_pkg::req_t item;
        int               gap;
        item.mode = op;
        item.operand_a = a;
        item.operand_b = b;
        item.bit_index = idx;
        {item.zero_in, item.subtract_in, item.half_carry_in, item.carry_in} = znhc;
        gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        owed_results.push_back('{src: item, want: alu_predict(item)});
        codes_seen[op] = 1'b1;
        ops_sent++;
    endtask

    // result side: stall at random, check each transfer against the oldest prediction
    initial
    begin
        int    hold;
        owed_t due;
        rsp_stall <= 1'b0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            begin
                results_checked++;
                if (owed_results.size() == 0)
                    report_mismatch($sformatf("unexpected result %h", rsp));
                else
                begin
                    due = owed_results.pop_front();
                    if (rsp.result !== due.want.result)
                        report_mismatch($sformatf("mode %0d result %h, want %h",
                            due.src.mode, rsp.result, due.want.result));
                    if (rsp.zero_out !== due.want.zero_out)
                        report_mismatch($sformatf("mode %0d Z %b, want %b",
                            due.src.mode, rsp.zero_out, due.want.zero_out));
                    if (rsp.subtract_out !== due.want.subtract_out)
                        report_mismatch($sformatf("mode %0d N %b, want %b",
                            due.src.mode, rsp.subtract_out, due.want.subtract_out));
                    if (rsp.half_carry_out !== due.want.half_carry_out)
                        report_mismatch($sformatf("mode %0d H %b, want %b",
                            due.src.mode, rsp.half_carry_out, due.want.half_carry_out));
                    if (rsp.carry_out !== due.want.carry_out)
                        report_mismatch($sformatf("mode %0d C %b, want %b",
                            due.src.mode, rsp.carry_out, due.want.carry_out));
                end
                hold = draw_wait(recv_calm);
            end
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                hold--;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    task automatic test_add_sub();
        send_op(cpualu_pkg::OP_ADD, 16'hFF0F, 16'hA001, 3'd0, 4'b1111);
        send_op(cpualu_pkg::OP_ADC, 16'h000F, 16'h00F0, 3'd0, 4'b0001);
        send_op(cpualu_pkg::OP_SUB, 16'h0010, 16'h0001, 3'd0, 4'b0000);
        send_op(cpualu_pkg::OP_SBC, 16'h0000, 16'h00FF, 3'd0, 4'b0001);
        send_op(cpualu_pkg::OP_CP, 16'h7742, 16'hFF42, 3'd0, 4'b0000);
    endtask

    task automatic test_logic();
        send_op(cpualu_pkg::OP_AND, 16'hFFFF, 16'hFFFF, 3'd0, 4'b0000);
        send_op(cpualu_pkg::OP_OR, 16'h0000, 16'h0000, 3'd0, 4'b0111);
        send_op(cpualu_pkg::OP_XOR, 16'h12AA, 16'h34AA, 3'd0, 4'b0001);
    endtask

    task automatic test_inc_dec();
        send_op(cpualu_pkg::OP_INC, 16'h0000, 16'h00FF, 3'd0, 4'b0101);
        send_op(cpualu_pkg::OP_DEC, 16'h0000, 16'hFF00, 3'd0, 4'b1010);
    endtask

    task automatic test_shifts();
        send_op(cpualu_pkg::OP_RLC, 16'h0000, 16'h0080, 3'd0, 4'b0000);
        send_op(cpualu_pkg::OP_RRC, 16'h0000, 16'h0001, 3'd0, 4'b1111);
        send_op(cpualu_pkg::OP_RL, 16'h0000, 16'h0080, 3'd0, 4'b0000);
        send_op(cpualu_pkg::OP_RR, 16'h0000, 16'h0000, 3'd0, 4'b0001);
        send_op(cpualu_pkg::OP_SLA, 16'h0000, 16'hFFFF, 3'd0, 4'b0000);
        send_op(cpualu_pkg::OP_SRA, 16'h0000, 16'h0081, 3'd0, 4'b0000);
        send_op(cpualu_pkg::OP_SRL, 16'h0000, 16'h0001, 3'd0, 4'b0110);
        send_op(cpualu_pkg::OP_SWAP, 16'h0000, 16'h00F0, 3'd0, 4'b0001);
        send_op(cpualu_pkg::OP_RLCA, 16'h0000, 16'h0000, 3'd0, 4'b1000);
        send_op(cpualu_pkg::OP_RRCA, 16'h0001, 16'h0000, 3'd0, 4'b0000);
        send_op(cpualu_pkg::OP_RLA, 16'h0080, 16'h0000, 3'd0, 4'b0001);
        send_op(cpualu_pkg::OP_RRA, 16'h0001, 16'h0000, 3'd0, 4'b1000);
    endtask

    task automatic test_bit_ops();
        send_op(cpualu_pkg::OP_BIT, 16'h0000, 16'h0080, 3'd7, 4'b0001);
        send_op(cpualu_pkg::OP_RES, 16'h0000, 16'hFFFF, 3'd7, 4'b1111);
        send_op(cpualu_pkg::OP_SET, 16'h0000, 16'h0000, 3'd0, 4'b0000);
    endtask

    task automatic test_daa_and_flag_ops();
        send_op(cpualu_pkg::OP_DAA, 16'h009A, 16'h0000, 3'd0, 4'b0000);
        send_op(cpualu_pkg::OP_DAA, 16'h000F, 16'h0000, 3'd0, 4'b0110);
        send_op(cpualu_pkg::OP_DAA, 16'h0000, 16'h0000, 3'd0, 4'b0001);
        send_op(cpualu_pkg::OP_CPL, 16'hAA55, 16'h0000, 3'd0, 4'b1000);
        send_op(cpualu_pkg::OP_CCF, 16'h1234, 16'h0000, 3'd0, 4'b1111);
        send_op(cpualu_pkg::OP_SCF, 16'h00FF, 16'h0000, 3'd0, 4'b0110);
    endtask

    task automatic test_wide_adds();
        send_op(cpualu_pkg::OP_ADD16, 16'h0FFF, 16'h0001, 3'd0, 4'b1100);
        send_op(cpualu_pkg::OP_ADD16, 16'hFFFF, 16'h0001, 3'd0, 4'b0011);
        send_op(cpualu_pkg::OP_ADDSP, 16'hFFF8, 16'h0008, 3'd0, 4'b1111);
        send_op(cpualu_pkg::OP_ADDSP, 16'h0000, 16'hFF80, 3'd0, 4'b0000);
    endtask

    task automatic test_unused_code();
        send_op(UnusedCode, 16'hBEEF, 16'h1234, 3'd5, 4'b1010);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_op(5'($urandom_range(0, 31)), pick_word(), pick_word(),
                    3'($urandom), 4'($urandom));
    endtask

    initial
    begin
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        mismatches = 0;
        results_checked = 0;
        ops_sent = 0;
        codes_seen = '0;
        send_calm = 0;
        recv_calm = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_add_sub();
        test_logic();
        test_inc_dec();
        test_shifts();
        test_bit_ops();
        test_daa_and_flag_ops();
        test_wide_adds();
        test_unused_code();
        test_random(600);
        req_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("%0d operations sent, %0d results checked, %0d of 32 mode codes used",
                 ops_sent, results_checked, $countones(codes_seen));
        $display("%0d mismatches", mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timed out with %0d results outstanding", owed_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/cpualu_pkg.sv
rtl/core/cpu_alu_with_flags.sv
test/testbench.sv
